// ===== rtl/core/hpt_pkg.sv =====
// Shared types, constants and the gamma threshold table for the HDR pixel tonemapper.
package hpt_pkg;

  localparam int unsigned QBITS       = 24;
  localparam int unsigned DIV_BITS    = 2;
  localparam int unsigned DIV_STAGES  = QBITS / DIV_BITS;
  localparam int unsigned GAM_STAGES  = 8;
  localparam int unsigned LANE_STAGES = 1 + DIV_STAGES + GAM_STAGES;
  localparam int unsigned DEN_W       = QBITS + 1;
  localparam int unsigned NUM_W       = 17;

  localparam logic [4:0] EXP_ALL_ONES = 5'h1f;
  localparam logic [4:0] EXP_BIAS_TOP = 5'd25;
  localparam logic [7:0] CODE_MAX     = 8'hff;

  typedef enum logic [1:0] {
    FMT_HALF_RGBA = 2'd0,
    FMT_BYTE_RGBA = 2'd1,
    FMT_BYTE_BGRA = 2'd2
  } fmt_e;

  typedef struct packed {
    logic                 spec;
    logic [7:0]           spec_code;
    logic [DEN_W-1:0]     rem;
    logic [DEN_W-1:0]     den;
    logic [QBITS-1:0]     quo;
  } div_t;

  typedef struct packed {
    logic             spec;
    logic [7:0]       spec_code;
    logic [QBITS-1:0] y;
    logic [7:0]       code;
  } gam_t;

  typedef logic [255:0][DEN_W-1:0] thr_tab_t;

  // Smallest 0.24 value y with y^5 * 510^11 >= (2k-1)^11 * 2^120, i.e. the exact
  // gamma 2.2 decision point between code k-1 and code k.
  function automatic thr_tab_t gen_thresholds();
    thr_tab_t     tab;
    logic [255:0] c510;
    logic [255:0] rhs;
    logic [255:0] lhs;
    logic [255:0] midw;
    logic [25:0]  lo;
    logic [25:0]  hi;
    logic [25:0]  mid;
    int           k;
    int           i;
    int           it;
    c510 = 256'd1;
    for (i = 0; i < 11; i++) c510 = c510 * 256'd510;
    tab[0] = '0;
    for (k = 1; k < 256; k++) begin
      rhs = 256'd1;
      for (i = 0; i < 11; i++) rhs = rhs * 256'(2 * k - 1);
      rhs = rhs << 120;
      lo  = 26'd0;
      hi  = 26'd1 << QBITS;
      for (it = 0; it < 26; it++) begin
        if (lo < hi) begin
          mid  = (lo + hi) >> 1;
          midw = 256'(mid);
          lhs  = midw * midw * midw * midw * midw * c510;
          if (lhs >= rhs) begin
            hi = mid;
          end else begin
            lo = mid + 26'd1;
          end
        end
      end
      tab[k] = DEN_W'(lo);
    end
    return tab;
  endfunction

  localparam thr_tab_t GAMMA_THR = gen_thresholds();

endpackage

// ===== rtl/core/hdr_pixel_tonemap_core.sv =====
// Top level of the HDR pixel tonemapper: handshake, stage control, lanes and output mux.
//
// One RGBA pixel enters per transaction and one RGBA8 pixel leaves per transaction, in
// order. The block accepts a new pixel on every clock as long as the output side keeps
// taking results; from input to output a pixel passes one decode stage, twelve divider
// stages that each resolve two quotient bits of the Reinhard ratio, eight stages of gamma
// threshold search that each settle one code bit, and the output register. A
// stall on the output freezes only stages that are full, so bubbles are squeezed out and
// nothing is dropped or repeated. In half-float mode red, green and blue are tone mapped
// with y = x/(1+x) and gamma 2.2 with round half up, alpha reads 255; negative, zero and
// NaN inputs give 0 and positive infinity gives 255. In the byte modes the low bytes pass
// through, with red and blue swapped in BGRA mode; format code 3 behaves as RGBA. The
// format register may be written only while no pixel is in flight.
module hdr_pixel_tonemap_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] red_in_i,
  input  logic [15:0] green_in_i,
  input  logic [15:0] blue_in_i,
  input  logic [15:0] alpha_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_out_o,
  output logic [7:0]  green_out_o,
  output logic [7:0]  blue_out_o,
  output logic [7:0]  alpha_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_pixel_format_i
);
  import hpt_pkg::*;

  localparam int unsigned NSTG = LANE_STAGES;

  logic [1:0]      pixel_format_q;
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] en;
  logic            en_out;
  logic [31:0]     byte_q [NSTG];
  logic            out_valid_q;
  logic [31:0]     out_q;
  logic [31:0]     out_d;
  logic [7:0]      code_r;
  logic [7:0]      code_g;
  logic [7:0]      code_b;

  // Configuration is always accepted.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pixel_format_q <= FMT_HALF_RGBA;
    end else if (cfg_valid_i) begin
      pixel_format_q <= cfg_pixel_format_i;
    end
  end

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en_out       = !out_valid_q || out_ready_i;
    en[NSTG-1]   = !vld_q[NSTG-1] || en_out;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld_q[i] <= vld_q[i-1];
      end
      if (en_out) out_valid_q <= vld_q[NSTG-1];
    end
  end

  // Low bytes travel beside the lanes for the passthrough modes.
  always_ff @(posedge clk_i) begin
    if (en[0]) byte_q[0] <= {alpha_in_i[7:0], blue_in_i[7:0], green_in_i[7:0], red_in_i[7:0]};
    for (int i = 1; i < NSTG; i++) begin
      if (en[i]) byte_q[i] <= byte_q[i-1];
    end
  end

  hpt_lane u_lane_r (.clk_i(clk_i), .en_i(en), .word_i(red_in_i),   .code_o(code_r));
  hpt_lane u_lane_g (.clk_i(clk_i), .en_i(en), .word_i(green_in_i), .code_o(code_g));
  hpt_lane u_lane_b (.clk_i(clk_i), .en_i(en), .word_i(blue_in_i),  .code_o(code_b));

  always_comb begin
    unique case (pixel_format_q)
      FMT_HALF_RGBA: out_d = {CODE_MAX, code_b, code_g, code_r};
      FMT_BYTE_BGRA: out_d = {byte_q[NSTG-1][31:24], byte_q[NSTG-1][7:0],
                              byte_q[NSTG-1][15:8], byte_q[NSTG-1][23:16]};
      default:       out_d = byte_q[NSTG-1];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_out) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_q[7:0];
  assign green_out_o = out_q[15:8];
  assign blue_out_o  = out_q[23:16];
  assign alpha_out_o = out_q[31:24];

  // With the output taking results, the whole pipe advances and input is open.
  a_ready_when_drained : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o) else $error("input stalled while output drains");

  // A full last stage that cannot move must face a held result.
  a_last_stage_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NSTG-1] && !en[NSTG-1]) |-> out_valid_q) else $error("last stage stalled wrongly");

  // Tonemap mode always reports opaque alpha.
  a_alpha_opaque : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (pixel_format_q == FMT_HALF_RGBA)) |-> (alpha_out_o == CODE_MAX))
    else $error("alpha not opaque in tonemap mode");

endmodule

// ===== rtl/core/hpt_lane.sv =====
// One color channel: binary16 decode, pipelined Reinhard divider and gamma code search.
module hpt_lane (
  input  logic                           clk_i,
  input  logic [hpt_pkg::LANE_STAGES-1:0] en_i,
  input  logic [15:0]                    word_i,
  output logic [7:0]                     code_o
);
  import hpt_pkg::*;

  div_t div_q [DIV_STAGES+1];
  div_t div_d [DIV_STAGES+1];
  gam_t gam_in [GAM_STAGES];
  gam_t gam_q [GAM_STAGES];
  gam_t gam_d [GAM_STAGES];

  logic                 sgn;
  logic [4:0]           ex;
  logic [9:0]           mn;
  logic [4:0]           ex_eff;
  logic [10:0]          sig;
  logic [NUM_W-1:0]     num_a;
  logic [DEN_W-1:0]     add_b;

  // Decode: y = a / (a + b), where a carries the scaled significand.
  always_comb begin
    sgn    = word_i[15];
    ex     = word_i[14:10];
    mn     = word_i[9:0];
    ex_eff = (ex == 5'd0) ? 5'd1 : ex;
    sig    = {(ex != 5'd0), mn};
    if (ex >= EXP_BIAS_TOP) begin
      num_a = NUM_W'(sig) << (ex - EXP_BIAS_TOP);
      add_b = DEN_W'(1);
    end else begin
      num_a = NUM_W'(sig);
      add_b = DEN_W'(1) << (EXP_BIAS_TOP - ex_eff);
    end
    div_d[0].spec      = sgn || (ex == EXP_ALL_ONES) || ((ex == 5'd0) && (mn == 10'd0));
    div_d[0].spec_code = (!sgn && (ex == EXP_ALL_ONES) && (mn == 10'd0)) ? CODE_MAX : 8'd0;
    div_d[0].rem       = DEN_W'(num_a);
    div_d[0].den       = DEN_W'(num_a) + add_b;
    div_d[0].quo       = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) div_q[0] <= div_d[0];
  end

  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    always_comb begin
      logic [DEN_W:0] t;
      logic           ge;
      div_d[j] = div_q[j-1];
      for (int s = 0; s < DIV_BITS; s++) begin
        t  = {div_d[j].rem, 1'b0};
        ge = (t >= {1'b0, div_d[j].den});
        if (ge) t = t - {1'b0, div_d[j].den};
        div_d[j].rem = t[DEN_W-1:0];
        div_d[j].quo = {div_d[j].quo[QBITS-2:0], ge};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i[j]) div_q[j] <= div_d[j];
    end
  end

  // Search for the largest code whose threshold y reaches, one code bit a stage.
  for (genvar g = 0; g < GAM_STAGES; g++) begin : g_gam
    if (g == 0) begin : g_head
      assign gam_in[g] = '{spec:      div_q[DIV_STAGES].spec,
                           spec_code: div_q[DIV_STAGES].spec_code,
                           y:         div_q[DIV_STAGES].quo,
                           code:      8'd0};
    end else begin : g_link
      assign gam_in[g] = gam_q[g-1];
    end
    always_comb begin
      logic [7:0] cand;
      gam_d[g] = gam_in[g];
      cand = gam_d[g].code | (8'd1 << (GAM_STAGES - 1 - g));
      if ({1'b0, gam_d[g].y} >= GAMMA_THR[cand]) gam_d[g].code = cand;
    end
    always_ff @(posedge clk_i) begin
      if (en_i[1 + DIV_STAGES + g]) gam_q[g] <= gam_d[g];
    end
  end

  assign code_o = gam_q[GAM_STAGES-1].spec ? gam_q[GAM_STAGES-1].spec_code
                                           : gam_q[GAM_STAGES-1].code;

endmodule
